// ===== rtl/ris_pkg.sv =====
// ----------------------------------------------------------------------------
// ris_pkg
// Shared types and constants for the rank insert sequence store.
// ----------------------------------------------------------------------------
package ris_pkg;

	localparam int DEPTH    = 64;
	localparam int KEY_BITS = 16;
	localparam int TAG_BITS = 7;
	// wide enough to hold DEPTH itself (entry count, rank, cell index)
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	typedef enum logic [1:0] {
		STAT_INS_DONE  = 2'd0,
		STAT_INS_FULL  = 2'd1,
		STAT_RD_ENTRY  = 2'd2,
		STAT_RD_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} ent_t;

	// broadcast command to every cell of the chain
	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] rank;      // insert slot
		logic [CNT_W-1:0] last_pos;  // highest occupied slot during rotate
		ent_t             new_ent;
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

endpackage

// ===== rtl/ris_cell.sv =====
// ----------------------------------------------------------------------------
// ris_cell
// One slot of the sequence: holds an entry, shifts up on insert, rotates
// down during readout.
// ----------------------------------------------------------------------------
module ris_cell (
	input  logic                      clk,
	input  logic [ris_pkg::CNT_W-1:0] index,
	input  ris_pkg::cell_cmd_t        cmd,
	input  ris_pkg::ent_t             left_ent,   // from slot index-1
	input  ris_pkg::ent_t             right_ent,  // from slot index+1
	input  ris_pkg::ent_t             head_ent,   // from slot 0
	output ris_pkg::ent_t             ent
);

	ris_pkg::ent_t ent_q;
	ris_pkg::ent_t ent_d;

	always_comb begin
		ent_d = ent_q;
		unique case (cmd.op)
			ris_pkg::CELL_INSERT: begin
				if (index > cmd.rank) begin
					ent_d = left_ent;
				end else if (index == cmd.rank) begin
					ent_d = cmd.new_ent;
				end
			end
			ris_pkg::CELL_ROTATE: begin
				if (index < cmd.last_pos) begin
					ent_d = right_ent;
				end else if (index == cmd.last_pos) begin
					ent_d = head_ent;
				end
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign ent = ent_q;

endmodule

// ===== rtl/ris_chain.sv =====
// ----------------------------------------------------------------------------
// ris_chain
// Row of DEPTH cells wired to their neighbors; slot 0 is the readout head.
// ----------------------------------------------------------------------------
module ris_chain (
	input  logic               clk,
	input  ris_pkg::cell_cmd_t cmd,
	output ris_pkg::ent_t      head
);

	ris_pkg::ent_t ents [ris_pkg::DEPTH];

	for (genvar i = 0; i < ris_pkg::DEPTH; i++) begin : g_cell
		ris_cell u_cell (
			.clk       (clk),
			.index     (ris_pkg::CNT_W'(i)),
			.cmd       (cmd),
			.left_ent  (ents[(i > 0) ? i - 1 : i]),
			.right_ent (ents[(i < ris_pkg::DEPTH - 1) ? i + 1 : i]),
			.head_ent  (ents[0]),
			.ent       (ents[i])
		);
	end

	assign head = ents[0];

endmodule

// ===== rtl/rank_insert_sequence_store_top.sv =====
// ----------------------------------------------------------------------------
// rank_insert_sequence_store_top
// Ordered key/tag sequence with insert-at-rank and in-order readout.
// ----------------------------------------------------------------------------
// The store keeps up to 64 entries in a row of cells. An insert item (kind 0)
// places {entry_key, position} at rank position (clamped to the current
// count, so a large position appends); the tag keeps the unclamped position.
// Every cell decides in the same cycle whether it keeps its entry, takes its
// lower neighbor's or takes the new one; an insert answers with one item:
// status 0, or status 1 when the store is full and the item is dropped. A
// readout item (kind 1) streams the entries in order, one item per cycle when
// the output side does not stall: the chain rotates down one slot per entry
// sent and slot 0 feeds the output register, so after count entries the
// contents are back in place; the block stays busy until the last entry is
// loaded. An empty store answers one item with status 3. The final item of
// each input item has last set. Insert items are accepted back to back while
// results are taken; a new item is not accepted while a readout is streaming.
// The output register decouples the sides: an item is accepted while the
// previous result is being taken. Entries are not cleared by reset; only the
// state, entry count, readout index and output valid flag are.
// ----------------------------------------------------------------------------
module rank_insert_sequence_store_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [ris_pkg::KEY_BITS-1:0] entry_key,
	input  logic [ris_pkg::TAG_BITS-1:0] position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ris_pkg::KEY_BITS-1:0] out_key,
	output logic [ris_pkg::TAG_BITS-1:0] out_tag,
	output logic [1:0]                   status,
	output logic                         last
);

	ris_pkg::state_t state_q, state_d;

	logic [ris_pkg::CNT_W-1:0]    count_q;
	logic [ris_pkg::CNT_W-1:0]    rd_idx_q;
	logic                         out_valid_q;
	logic [ris_pkg::KEY_BITS-1:0] out_key_q;
	logic [ris_pkg::TAG_BITS-1:0] out_tag_q;
	ris_pkg::status_t             status_q;
	logic                         last_q;

	// control outputs
	logic                  slot_free;
	logic                  in_fire;
	logic                  full;
	logic                  rd_last;
	logic                  out_load;
	ris_pkg::ent_t         out_ent_d;
	ris_pkg::status_t      status_d;
	logic                  last_d;
	logic                  count_inc;
	logic                  rd_start;
	logic                  rd_step;
	ris_pkg::cell_cmd_t    cmd;
	ris_pkg::ent_t         head;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ris_pkg::ST_IDLE) && slot_free;
	assign in_fire   = in_valid && in_ready;
	assign full      = (count_q == ris_pkg::CNT_W'(ris_pkg::DEPTH));
	assign rd_last   = (rd_idx_q == count_q - ris_pkg::CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ris_pkg::ST_IDLE: begin
				if (in_fire && (kind == ris_pkg::KIND_READOUT) &&
				    (count_q != '0)) begin
					state_d = ris_pkg::ST_READ;
				end
			end
			ris_pkg::ST_READ: begin
				if (slot_free && rd_last) begin
					state_d = ris_pkg::ST_IDLE;
				end
			end
			default: state_d = ris_pkg::ST_IDLE;
		endcase
	end

	// outputs: chain command and result register load
	always_comb begin
		cmd          = '0;
		cmd.op       = ris_pkg::CELL_HOLD;
		cmd.new_ent  = '{key: entry_key, tag: position};
		cmd.last_pos = count_q - ris_pkg::CNT_W'(1);
		cmd.rank     = (position > ris_pkg::TAG_BITS'(count_q)) ?
		               count_q : ris_pkg::CNT_W'(position);
		out_load     = 1'b0;
		out_ent_d    = '0;
		status_d     = ris_pkg::STAT_INS_DONE;
		last_d       = 1'b1;
		count_inc    = 1'b0;
		rd_start     = 1'b0;
		rd_step      = 1'b0;
		unique case (state_q)
			ris_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (kind == ris_pkg::KIND_INSERT) begin
						out_load = 1'b1;
						if (full) begin
							status_d = ris_pkg::STAT_INS_FULL;
						end else begin
							cmd.op    = ris_pkg::CELL_INSERT;
							count_inc = 1'b1;
						end
					end else if (count_q == '0) begin
						out_load = 1'b1;
						status_d = ris_pkg::STAT_RD_EMPTY;
					end else begin
						rd_start = 1'b1;
					end
				end
			end
			ris_pkg::ST_READ: begin
				if (slot_free) begin
					out_load  = 1'b1;
					out_ent_d = head;
					status_d  = ris_pkg::STAT_RD_ENTRY;
					last_d    = rd_last;
					cmd.op    = ris_pkg::CELL_ROTATE;
					rd_step   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	ris_chain u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.head (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ris_pkg::ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_inc) begin
				count_q <= count_q + ris_pkg::CNT_W'(1);
			end
			if (rd_start) begin
				rd_idx_q <= '0;
			end else if (rd_step) begin
				rd_idx_q <= rd_idx_q + ris_pkg::CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_key_q <= out_ent_d.key;
			out_tag_q <= out_ent_d.tag;
			status_q  <= status_d;
			last_q    <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign status    = status_q;
	assign last      = last_q;

	// count never exceeds the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ris_pkg::CNT_W'(ris_pkg::DEPTH))
		else $error("entry count above depth");

	// count moves only after an accepted insert
	a_count_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(in_fire && (kind == ris_pkg::KIND_INSERT)))
		else $error("entry count changed without insert");

	// the final readout entry ends the stream
	a_read_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ris_pkg::ST_READ && slot_free && rd_last) |=>
		(state_q == ris_pkg::ST_IDLE && out_valid_q && last_q))
		else $error("readout did not end on last entry");

	// readout index stays inside the occupied slots
	a_rd_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ris_pkg::ST_READ) |-> (rd_idx_q < count_q))
		else $error("readout index beyond count");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rank insert sequence store. A scoreboard keeps
// its own copy of the ordered entries, predicts the results of every accepted
// item and checks each returned item against the oldest one still due.
// ----------------------------------------------------------------------------
module testbench;

	// random part: four idling phases of equal length
	localparam int RANDOM_ITEMS = 360;
	localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
	localparam int REPORT_MAX   = 10;
	// percent of random items that are inserts; keeps the store filling
	// slowly enough that readouts see many fill levels before it is full
	localparam int INSERT_PCT   = 30;

	// one result item as the block presents it
	typedef struct packed {
		logic [ris_pkg::KEY_BITS-1:0] key;
		logic [ris_pkg::TAG_BITS-1:0] tag;
		logic [1:0]                   status;
		logic                         last;
	} store_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirror of the ordered store plus the queue of due results.
	// ------------------------------------------------------------------------
	class store_scoreboard;
		logic [ris_pkg::KEY_BITS-1:0] mirror_keys[ris_pkg::DEPTH];
		logic [ris_pkg::TAG_BITS-1:0] mirror_tags[ris_pkg::DEPTH];
		int                           mirror_count;
		store_result_t                due_results[$];
		int n_inserts, n_dropped, n_readouts, n_empty, n_checked, n_errors;

		function new();
			mirror_count = 0;
			n_inserts    = 0;
			n_dropped    = 0;
			n_readouts   = 0;
			n_empty      = 0;
			n_checked    = 0;
			n_errors     = 0;
		endfunction

		// append one result to the tail of the due queue
		function void add_due(store_result_t res);
			due_results = {due_results, res};
		endfunction

		// update the mirror for one accepted item and queue its results
		function void apply_item(logic item_kind, logic [ris_pkg::KEY_BITS-1:0] item_key,
				logic [ris_pkg::TAG_BITS-1:0] item_pos);
			int rank;
			int j;
			if (item_kind == ris_pkg::KIND_INSERT) begin
				n_inserts++;
				if (mirror_count >= ris_pkg::DEPTH) begin
					// full: store unchanged, item dropped
					n_dropped++;
					add_due(store_result_t'{'0, '0, ris_pkg::STAT_INS_FULL, 1'b1});
				end else begin
					// rank clamps to the count; the tag keeps the raw position
					rank = (int'(item_pos) > mirror_count) ? mirror_count : int'(item_pos);
					for (j = mirror_count; j > rank; j--) begin
						mirror_keys[j] = mirror_keys[j-1];
						mirror_tags[j] = mirror_tags[j-1];
					end
					mirror_keys[rank] = item_key;
					mirror_tags[rank] = item_pos;
					mirror_count++;
					add_due(store_result_t'{'0, '0, ris_pkg::STAT_INS_DONE, 1'b1});
				end
			end else begin
				n_readouts++;
				if (mirror_count == 0) begin
					n_empty++;
					add_due(store_result_t'{'0, '0, ris_pkg::STAT_RD_EMPTY, 1'b1});
				end else begin
					for (j = 0; j < mirror_count; j++)
						add_due(store_result_t'{mirror_keys[j], mirror_tags[j],
							ris_pkg::STAT_RD_ENTRY, (j == mirror_count - 1)});
				end
			end
		endfunction

		// compare one accepted result item with the oldest due one
		function void check_result(logic [ris_pkg::KEY_BITS-1:0] got_key,
				logic [ris_pkg::TAG_BITS-1:0] got_tag, logic [1:0] got_status,
				logic got_last);
			store_result_t want;
			if (due_results.size() == 0) begin
				n_errors++;
				if (n_errors <= REPORT_MAX)
					$display("%0t: result with nothing due: key %h tag %0d status %0d last %0b",
						$time, got_key, got_tag, got_status, got_last);
				return;
			end
			want = due_results.pop_front();
			n_checked++;
			if (want.key !== got_key || want.tag !== got_tag ||
					want.status !== got_status || want.last !== got_last) begin
				n_errors++;
				if (n_errors <= REPORT_MAX)
					$display({"%0t: mismatch: expected key %h tag %0d status %0d last %0b,",
						" got key %h tag %0d status %0d last %0b"},
						$time, want.key, want.tag, want.status, want.last,
						got_key, got_tag, got_status, got_last);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block and its signals; every input starts at a known value.
	// ------------------------------------------------------------------------
	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	logic                         kind      = ris_pkg::KIND_INSERT;
	logic [ris_pkg::KEY_BITS-1:0] entry_key = '0;
	logic [ris_pkg::TAG_BITS-1:0] position  = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [ris_pkg::KEY_BITS-1:0] out_key;
	logic [ris_pkg::TAG_BITS-1:0] out_tag;
	logic [1:0]                   status;
	logic                         last;

	// idling odds in percent, changed per phase by the stimulus process
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	store_scoreboard sb;

	rank_insert_sequence_store_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.entry_key (entry_key),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.status    (status),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hang guard. Slowest sane run: ~370 items, each readout up to 64 items,
	// each result behind an 88% stall plus sender gaps; the time limit below
	// leaves a wide margin over that.
	initial begin
		#(20_000_000);
		$display("testbench: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: check every accepted result, then pick ready for the next
	// cycle. Sampling at the edge sees pre-edge values, so no race.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_key, out_tag, status, last);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Sender tasks
	// ------------------------------------------------------------------------

	// Present one item and hold it until accepted. Idle cycles come first, so
	// valid is never dropped and raised in the same step.
	task automatic send_item(input logic item_kind,
			input logic [ris_pkg::KEY_BITS-1:0] item_key,
			input logic [ris_pkg::TAG_BITS-1:0] item_pos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= item_kind;
		entry_key <= item_key;
		position  <= item_pos;
		do @(posedge clk); while (!in_ready);
		sb.apply_item(item_kind, item_key, item_pos);
	endtask

	// Stop sending until every due result has come back.
	task automatic wait_store_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due_results.size() != 0);
	endtask

	// Random item: mostly readouts, inserts aimed at front, tail, exact
	// append, inside the sequence and well past the end.
	task automatic send_random_item();
		int cnt;
		int pick;
		logic [ris_pkg::TAG_BITS-1:0] pos;
		cnt  = sb.mirror_count;
		pick = $urandom_range(99);
		if ($urandom_range(99) >= INSERT_PCT) begin
			send_item(ris_pkg::KIND_READOUT, ris_pkg::KEY_BITS'($urandom),
				ris_pkg::TAG_BITS'($urandom));
		end else begin
			if (pick < 30)
				pos = ris_pkg::TAG_BITS'($urandom_range(cnt, 0));
			else if (pick < 45)
				pos = '0;
			else if (pick < 55)
				pos = ris_pkg::TAG_BITS'(cnt);
			else if (pick < 70)
				pos = ris_pkg::TAG_BITS'((cnt > 0) ? cnt - 1 : 0);
			else if (pick < 85)
				pos = ris_pkg::TAG_BITS'($urandom_range(127, cnt));
			else
				pos = ris_pkg::TAG_BITS'($urandom);
			send_item(ris_pkg::KIND_INSERT, ris_pkg::KEY_BITS'($urandom), pos);
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int phase;
		int n;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty readout, front/middle/tail inserts, positions past
		// the count (tag keeps the raw value), key extremes
		send_item(ris_pkg::KIND_READOUT, 16'hFFFF, 7'h7F);
		send_item(ris_pkg::KIND_INSERT,  16'h0000, 7'd0);
		send_item(ris_pkg::KIND_INSERT,  16'hFFFF, 7'd127);
		send_item(ris_pkg::KIND_READOUT, 16'h0000, 7'd0);
		send_item(ris_pkg::KIND_INSERT,  16'h1234, 7'd0);
		send_item(ris_pkg::KIND_INSERT,  16'h5555, 7'd2);
		send_item(ris_pkg::KIND_INSERT,  16'hAAAA, 7'd4);
		send_item(ris_pkg::KIND_INSERT,  16'h8001, 7'd64);
		send_item(ris_pkg::KIND_INSERT,  16'h7FFE, 7'd1);
		send_item(ris_pkg::KIND_READOUT, 16'h0000, 7'd0);
		send_item(ris_pkg::KIND_INSERT,  16'h0F0F, 7'd63);
		send_item(ris_pkg::KIND_INSERT,  16'hF0F0, 7'd3);
		send_item(ris_pkg::KIND_READOUT, 16'hFFFF, 7'd127);

		// sender holds off until the store has answered everything
		wait_store_drained();

		// random: no idling, sender idle, receiver stalling, both lightly
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				send_random_item();
			wait_store_drained();
		end

		// a readout streams up to DEPTH items after its lead-in
		repeat (2 * ris_pkg::DEPTH + 8) @(posedge clk);

		$display("covered %0d inserts (%0d dropped on a full store), %0d readouts (%0d empty)",
			sb.n_inserts, sb.n_dropped, sb.n_readouts, sb.n_empty);
		$display("checked %0d result items, %0d errors, final fill %0d of %0d",
			sb.n_checked, sb.n_errors, sb.mirror_count, ris_pkg::DEPTH);
		if (sb.n_errors == 0 && sb.due_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ris_pkg.sv
rtl/ris_cell.sv
rtl/ris_chain.sv
rtl/rank_insert_sequence_store_top.sv
bench/testbench.sv
